FILE: rtl/hhdd_pkg.sv
package hhdd_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int COUNT_BITS    = 32;
    localparam int ADDR_W        = 32;
    localparam int FIELD_W       = 32;
    localparam int SHARE_W       = 8;
    localparam int PROD_W        = COUNT_BITS + SHARE_W;
    localparam int CFG_IDX_W     = 2;

    localparam logic [FIELD_W-1:0] MIN_PACKETS_RST = FIELD_W'(1000);
    localparam logic [SHARE_W-1:0] SHARE_NUM_RST   = SHARE_W'(4);
    localparam logic [SHARE_W-1:0] SHARE_DEN_RST   = SHARE_W'(5);

    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [PROD_W-1:0]     t_prod;
    typedef logic [ADDR_W-1:0]     t_addr;
    typedef logic [FIELD_W-1:0]    t_field;
    typedef logic [SHARE_W-1:0]    t_share;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;

    localparam t_idx   IDX_LAST  = '1;
    localparam t_count COUNT_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_PACKETS = 2'd0,
        REG_SHARE_NUM   = 2'd1,
        REG_SHARE_DEN   = 2'd2
    } t_reg;

    typedef struct packed {
        logic   valid;
        t_addr  key;
        t_count count;
    } t_entry;

    function automatic t_count sat_inc(input t_count v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic t_field sat_field(input t_count v);
        logic [63:0] w;
        w = 64'(v);
        return (w > 64'({FIELD_W{1'b1}})) ? '1 : w[FIELD_W-1:0];
    endfunction

endpackage

FILE: rtl/hhdd_ifs.sv
interface hhdd_in_if;
    import hhdd_pkg::*;
    logic  valid;
    logic  ready;
    t_addr dst_addr;
    logic  last;
    modport source (output valid, output dst_addr, output last, input ready);
    modport sink   (input valid, input dst_addr, input last, output ready);
endinterface

interface hhdd_out_if;
    import hhdd_pkg::*;
    logic   valid;
    logic   ready;
    logic   flagged;
    t_field packets_seen;
    modport source (output valid, output flagged, output packets_seen, input ready);
    modport sink   (input valid, input flagged, input packets_seen, output ready);
endinterface

interface hhdd_cfg_if;
    import hhdd_pkg::*;
    logic     valid;
    logic     ready;
    t_cfg_idx index;
    t_field   data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/hhdd_ram.sv
module hhdd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/heavy_hitter_destination_detector_core.sv
// An accepted item is probed in S_EVAL from its home slot onwards until a slot holds the
// address or is free, or every slot has been probed; no new item is accepted meanwhile.
// A last item is followed by a sweep over the slot RAM, which checks the share threshold
// and clears every slot, then by S_DRAIN1, S_DRAIN2 and S_RES, which loads the result register.
// Reset is synchronous; after it a clearing pass runs over the slot
// RAM with no items accepted, while configuration writes are taken.
module heavy_hitter_destination_detector_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hhdd_in_if.sink     i_pkt,
    hhdd_cfg_if.sink    i_cfg,
    hhdd_out_if.source  o_res
);
    import hhdd_pkg::*;

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_EVAL   = 7'b0000100,
        S_SCAN   = 7'b0001000,
        S_DRAIN1 = 7'b0010000,
        S_DRAIN2 = 7'b0100000,
        S_RES    = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    t_idx   r_pos;
    t_idx   r_probe;
    t_idx   r_cnt;
    t_addr  r_addr;
    logic   r_last;
    t_count r_total;
    t_prod  r_bound;
    t_prod  r_prod;
    logic   r_prod_v;
    logic   r_sv1;
    logic   r_en;
    logic   r_hot;
    t_field r_min;
    t_share r_num;
    t_share r_den;
    logic   r_out_valid;
    logic   r_flagged;
    t_field r_seen;

    logic   wr_en;
    t_idx   wr_addr;
    t_entry wr_data;
    t_idx   rd_addr;
    t_entry rd_data;
    logic   accept;
    logic   hit;
    logic   done;
    logic   load;

    hhdd_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_ENTRIES)
    ) u_slots (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign accept      = i_pkt.valid & i_pkt.ready;
    assign i_pkt.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign hit         = rd_data.valid && (rd_data.key == r_addr);
    assign load        = (r_state == S_RES) && (!r_out_valid || o_res.ready);

    assign o_res.valid        = r_out_valid;
    assign o_res.flagged      = r_flagged;
    assign o_res.packets_seen = r_seen;

    always_comb begin
        n_state = r_state;
        wr_en   = 1'b0;
        wr_addr = r_pos;
        wr_data = '0;
        rd_addr = r_pos;
        done    = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                rd_addr = r_cnt;
                wr_en   = 1'b1;
                wr_addr = r_cnt;
                if (r_cnt == IDX_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                rd_addr = i_pkt.dst_addr[IDX_W-1:0];
                if (accept) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                rd_addr = r_pos + 1'b1;
                if (hit) begin
                    wr_en   = 1'b1;
                    wr_data = '{valid: 1'b1, key: r_addr, count: sat_inc(rd_data.count)};
                    done    = 1'b1;
                end else if (!rd_data.valid) begin
                    wr_en   = 1'b1;
                    wr_data = '{valid: 1'b1, key: r_addr, count: t_count'(1)};
                    done    = 1'b1;
                end else if (r_probe == IDX_LAST) begin
                    done = 1'b1;
                end
                if (done) begin
                    n_state = r_last ? S_SCAN : S_IDLE;
                end
            end
            S_SCAN: begin
                rd_addr = r_cnt;
                wr_en   = 1'b1;
                wr_addr = r_cnt;
                if (r_cnt == IDX_LAST) begin
                    n_state = S_DRAIN1;
                end
            end
            S_DRAIN1: n_state = S_DRAIN2;
            S_DRAIN2: n_state = S_RES;
            S_RES: begin
                if (load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_total     <= '0;
            r_sv1       <= 1'b0;
            r_prod_v    <= 1'b0;
            r_hot       <= 1'b0;
            r_en        <= 1'b0;
            r_out_valid <= 1'b0;
            r_min       <= MIN_PACKETS_RST;
            r_num       <= SHARE_NUM_RST;
            r_den       <= SHARE_DEN_RST;
        end else begin
            r_state  <= n_state;
            r_sv1    <= (r_state == S_SCAN);
            r_prod_v <= r_sv1 && rd_data.valid;
            if (r_state == S_CLEAR || r_state == S_SCAN) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (accept) begin
                r_total <= sat_inc(r_total);
            end
            if (r_state == S_EVAL && done && r_last) begin
                r_hot <= 1'b0;
                r_en  <= 64'(r_total) >= 64'(r_min);
                r_cnt <= '0;
            end else begin
                r_hot <= r_hot | (r_prod_v && (r_prod > r_bound));
            end
            if (load) begin
                r_out_valid <= 1'b1;
                r_total     <= '0;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    REG_MIN_PACKETS: r_min <= i_cfg.data;
                    REG_SHARE_NUM:   r_num <= i_cfg.data[SHARE_W-1:0];
                    REG_SHARE_DEN:   r_den <= i_cfg.data[SHARE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= t_prod'(rd_data.count) * t_prod'(r_den);
        if (accept) begin
            r_addr  <= i_pkt.dst_addr;
            r_last  <= i_pkt.last;
            r_pos   <= i_pkt.dst_addr[IDX_W-1:0];
            r_probe <= '0;
        end else if (r_state == S_EVAL) begin
            r_pos   <= r_pos + 1'b1;
            r_probe <= r_probe + 1'b1;
        end
        if (r_state == S_EVAL) begin
            r_bound <= t_prod'(r_total) * t_prod'(r_num);
        end
        if (load) begin
            r_flagged <= r_hot & r_en;
            r_seen    <= sat_field(r_total);
        end
    end

`ifndef NO_ASSERTIONS
    a_sweep_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_CLEAR) |-> (wr_en && !wr_data.valid))
        else $error("sweep does not clear the slot it visits");

    a_accept_to_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_EVAL))
        else $error("accepted transfer not followed by a probe");

    a_total_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |=> (r_total == $past(r_total)))
        else $error("packet total changed during a probe");

    a_result_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RES && r_out_valid && !o_res.ready) |=> (r_state == S_RES))
        else $error("result register overwritten before transfer");
`endif

endmodule
